// ----- design/ppc_pkg.sv -----
package ppc_pkg;

  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned ProdW = 15;
  localparam int unsigned DivW = 8;

  localparam logic [CfgIdxW-1:0] CfgNearLimit = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenDist = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCenterX = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCenterY = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgViewLeft = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgViewRight = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgViewTop = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgViewBottom = 3'd7;

  localparam logic [5:0] ClipNear = 6'h01;
  localparam logic [5:0] ClipFar = 6'h02;
  localparam logic [5:0] ClipLeft = 6'h04;
  localparam logic [5:0] ClipRight = 6'h08;
  localparam logic [5:0] ClipTop = 6'h10;
  localparam logic [5:0] ClipBottom = 6'h20;

  typedef struct packed {
    logic signed [7:0] vert_x;
    logic signed [7:0] vert_y;
    logic signed [7:0] vert_z;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic signed [7:0] pos_z;
    logic              last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [5:0] clip_code;
    logic [7:0] screen_x;
    logic [7:0] screen_y;
    logic [5:0] model_clip_or;
    logic       last_out;
  } out_item_t;

endpackage

// ----- design/ppc_if.sv -----
interface ppc_in_if;
  logic               valid;
  logic               ready;
  ppc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppc_out_if;
  logic               valid;
  logic               ready;
  ppc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/perspective_project_clip_unit.sv -----
// Perspective projection with clip outcodes for one model vertex per transaction.
// The input channel carries a model vertex, the model position and a flag that
// marks the last vertex of a model. The output channel returns the clip code,
// the screen position (zero when clipped), the running OR of clip codes over
// the model and a copy of the last flag. Eight configuration registers are
// written through a plain write port; the user must do so only while the unit
// is idle, since the block itself does not enforce it. One vertex is in flight
// at a time. After input acceptance the running clip OR is read from a one-entry
// RAM, the two scaled coordinates are formed in the multiply state, and two
// restoring dividers, one per axis, divide by depth before the result is
// registered. The input is ready again in the cycle after the result is
// registered, so no new vertex is taken before the last one is through.
// The result sits in an output register; a stalled receiver holds it there and
// the next vertex is processed up to the point of its result, where it waits.
// Reset loads the register defaults and clears the running clip OR; no
// clearing pass is needed.
module perspective_project_clip_unit #(
  parameter int unsigned DEPTH_RANGE = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ppc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ppc_pkg::CfgDataW-1:0] cfg_data_i,
  ppc_in_if.sink                      in_i,
  ppc_out_if.source                   out_o
);
  import ppc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;
  localparam logic signed [9:0] DepthLim = 10'(DEPTH_RANGE);

  logic [6:0] near_q;
  logic [7:0] dist_q, cx_q, cy_q, left_q, right_q, top_q, bottom_q;

  logic [2:0] state_q, state_d;
  logic signed [9:0] x_q, y_q, z_q;
  logic last_q;
  logic [ProdW-1:0] px_q, py_q, qx, qy;
  logic [5:0] acc_q, acc_rd;
  logic acc_vld_q;
  logic done_x, done_y;
  out_item_t out_q;
  logic out_vld_q;

  logic in_fire, fin_go;
  logic [9:0] ax, ay;
  logic signed [9:0] ext_l, ext_r, ext_t, ext_b;
  logic is_near, is_far;
  logic [5:0] code, total;
  logic [1:0] bx, by;
  logic [7:0] sx, sy;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire = in_i.valid && in_i.ready;
  assign fin_go = (state_q == S_FIN) && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= 7'd32;
      dist_q <= 8'd80;
      cx_q <= 8'd128;
      cy_q <= 8'd104;
      left_q <= 8'd0;
      right_q <= 8'd255;
      top_q <= 8'd0;
      bottom_q <= 8'd208;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNearLimit: near_q <= cfg_data_i[6:0];
        CfgScreenDist: dist_q <= cfg_data_i;
        CfgCenterX: cx_q <= cfg_data_i;
        CfgCenterY: cy_q <= cfg_data_i;
        CfgViewLeft: left_q <= cfg_data_i;
        CfgViewRight: right_q <= cfg_data_i;
        CfgViewTop: top_q <= cfg_data_i;
        CfgViewBottom: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_MUL;
      S_MUL: state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV: if (done_x && done_y) state_d = S_FIN;
      S_FIN: if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_vld_q <= 1'b0;
      acc_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_vld_q <= 1'b1;
        acc_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign ax = x_q[9] ? 10'(-x_q) : x_q;
  assign ay = y_q[9] ? 10'(-y_q) : y_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= 10'(in_i.data.vert_x) + 10'(in_i.data.pos_x);
      y_q <= 10'(in_i.data.vert_y) + 10'(in_i.data.pos_y);
      z_q <= 10'(in_i.data.vert_z) + 10'(in_i.data.pos_z);
      last_q <= in_i.data.last_vertex;
    end
    if (state_q == S_MUL) begin
      px_q <= {7'd0, dist_q} * {8'd0, ax[6:0]};
      py_q <= {7'd0, dist_q} * {8'd0, ay[6:0]};
      acc_q <= acc_vld_q ? acc_rd : 6'd0;
    end
    if (fin_go) begin
      out_q <= '{clip_code: code, screen_x: sx, screen_y: sy,
                 model_clip_or: total, last_out: last_q};
    end
  end

  ppc_ram #(.WIDTH(6), .DEPTH(1)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (fin_go),
    .waddr_i (1'b0),
    .wdata_i (last_q ? 6'd0 : total),
    .re_i    (in_fire),
    .raddr_i (1'b0),
    .rdata_o (acc_rd)
  );

  ppc_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_START),
    .dividend_i (px_q),
    .divisor_i  (z_q[7:0]),
    .done_o     (done_x),
    .quot_o     (qx)
  );

  ppc_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_START),
    .dividend_i (py_q),
    .divisor_i  (z_q[7:0]),
    .done_o     (done_y),
    .quot_o     (qy)
  );

  assign ext_l = $signed({2'b0, cx_q}) - $signed({2'b0, left_q});
  assign ext_r = $signed({2'b0, right_q}) - $signed({2'b0, cx_q});
  assign ext_t = $signed({2'b0, cy_q}) - $signed({2'b0, top_q});
  assign ext_b = $signed({2'b0, bottom_q}) - $signed({2'b0, cy_q});

  assign is_near = z_q < $signed({3'b0, near_q});
  assign is_far = z_q >= DepthLim;

  always_comb begin
    bx = 2'b00;
    by = 2'b00;
    if (x_q != '0) begin
      if (ax > 10'd127 || z_q <= 0 ||
          $signed({1'b0, qx}) >= 16'(x_q[9] ? ext_l : ext_r)) begin
        bx = x_q[9] ? 2'b01 : 2'b10;
      end
    end
    if (y_q != '0) begin
      if (ay > 10'd127 || z_q <= 0 ||
          $signed({1'b0, qy}) >= 16'(y_q[9] ? ext_t : ext_b)) begin
        by = y_q[9] ? 2'b01 : 2'b10;
      end
    end
    if (is_near) begin
      code = ClipNear;
    end else if (is_far) begin
      code = ClipFar;
    end else begin
      code = {by, bx, 2'b00};
    end
    total = acc_q | code;
    if (code == '0) begin
      sx = (x_q == '0) ? cx_q : (x_q[9] ? cx_q - qx[7:0] : cx_q + qx[7:0]);
      sy = (y_q == '0) ? cy_q : (y_q[9] ? cy_q - qy[7:0] : cy_q + qy[7:0]);
    end else begin
      sx = 8'd0;
      sy = 8'd0;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data = out_q;

endmodule

// ----- design/ppc_ram.sv -----
module ppc_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 1,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/ppc_div.sv -----
module ppc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ppc_pkg::ProdW-1:0] dividend_i,
  input  logic [ppc_pkg::DivW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [ppc_pkg::ProdW-1:0] quot_o
);
  import ppc_pkg::*;

  logic [ProdW-1:0] quo_q, quo_d;
  logic [DivW-1:0]  rem_q, rem_d, dsr_q;
  logic [3:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DivW:0]    shifted, trial;

  assign shifted = {rem_q, quo_q[ProdW-1]};
  assign trial = shifted - {1'b0, dsr_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = 4'(ProdW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivW-1:0];
        quo_d = {quo_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- design/ppc_checker.sv -----
module ppc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] clip_code,
  input logic [7:0] screen_x,
  input logic [7:0] screen_y,
  input logic [5:0] model_clip_or
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(clip_code))
    else $error("Result changed while stalled.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("Second transaction accepted while one is in progress.");

  a_clipped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && clip_code != 6'd0 |-> screen_x == 8'd0 && screen_y == 8'd0)
    else $error("Clipped vertex has a nonzero screen position.");

  a_or_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (model_clip_or & clip_code) == clip_code)
    else $error("Model clip OR misses a bit of the clip code.");

  a_depth_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && clip_code[1:0] != 2'b00 |-> clip_code[1:0] != 2'b11 &&
      clip_code[5:2] == 4'd0)
    else $error("Depth clip combined with another clip bit.");

endmodule

bind perspective_project_clip_unit ppc_checker u_ppc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .clip_code     (out_o.data.clip_code),
  .screen_x      (out_o.data.screen_x),
  .screen_y      (out_o.data.screen_y),
  .model_clip_or (out_o.data.model_clip_or)
);
